/* rtl/afsw_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the affine forward splat warp.
// No dependencies.
package afsw_pkg;

  localparam int COORD_BITS    = 12;
  localparam int FRAC_BITS     = 16;
  localparam int MAX_SPLAT_DEF = 8;
  localparam int COEF_W        = 32;
  localparam int CHAN_W        = 8;
  localparam int CFG_IDX_W     = 4;
  localparam int LIM_W         = COORD_BITS + 1;
  localparam int PROD_W        = COEF_W + COORD_BITS + 1;
  localparam int ACC_W         = PROD_W + 2;
  localparam int POS_W         = ACC_W - FRAC_BITS + 2;
  localparam int Q_DEPTH       = 2;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_XX  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_XY  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_YX  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_YY  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_DST_COLS = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_DST_ROWS = CFG_IDX_W'(7);

  localparam logic [COEF_W-1:0] RST_COEF_ONE = COEF_W'(1) << FRAC_BITS;
  localparam logic [LIM_W-1:0]  RST_DST_COLS = LIM_W'(640);
  localparam logic [LIM_W-1:0]  RST_DST_ROWS = LIM_W'(480);
  localparam logic [LIM_W-1:0]  LIM_MAX      = LIM_W'(1) << COORD_BITS;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_xx;
    logic signed [COEF_W-1:0] coef_xy;
    logic signed [COEF_W-1:0] offset_x;
    logic signed [COEF_W-1:0] coef_yx;
    logic signed [COEF_W-1:0] coef_yy;
    logic signed [COEF_W-1:0] offset_y;
    logic [LIM_W-1:0]         col_lim;
    logic [LIM_W-1:0]         row_lim;
  } cfg_t;

  // clipped write window of one source pixel, hi bounds exclusive
  typedef struct packed {
    logic [LIM_W-1:0]  col_lo;
    logic [LIM_W-1:0]  col_hi;
    logic [LIM_W-1:0]  row_lo;
    logic [LIM_W-1:0]  row_hi;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } span_t;

endpackage

/* rtl/afsw_cfg.sv */
`timescale 1ns / 1ps
// Configuration registers, clipping bounds and splat side derivation.
// Depends on afsw_pkg.
module afsw_cfg #(
  parameter int MAX_SPLAT = afsw_pkg::MAX_SPLAT_DEF,
  localparam int SIDE_W   = $clog2(MAX_SPLAT + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [afsw_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [afsw_pkg::COEF_W-1:0]      cfg_data_i,
  output afsw_pkg::cfg_t                   cfg_o,
  output logic [SIDE_W-1:0]                side_o
);

  localparam int UP_W = afsw_pkg::COEF_W + 2;
  localparam logic [UP_W-1:0] ROUND_UP = UP_W'((64'd1 << afsw_pkg::FRAC_BITS) - 64'd1);

  logic signed [afsw_pkg::COEF_W-1:0] coef_xx_q, coef_xy_q, offset_x_q;
  logic signed [afsw_pkg::COEF_W-1:0] coef_yx_q, coef_yy_q, offset_y_q;
  logic [afsw_pkg::LIM_W-1:0]         dst_cols_q, dst_rows_q;
  logic signed [afsw_pkg::COEF_W-1:0] mx_a, mx_b, mx_d, mx_q;
  logic [UP_W-1:0]                    up_w, sq_w;
  logic [SIDE_W-1:0]                  side_d, side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_xx_q  <= afsw_pkg::RST_COEF_ONE;
      coef_xy_q  <= '0;
      offset_x_q <= '0;
      coef_yx_q  <= '0;
      coef_yy_q  <= afsw_pkg::RST_COEF_ONE;
      offset_y_q <= '0;
      dst_cols_q <= afsw_pkg::RST_DST_COLS;
      dst_rows_q <= afsw_pkg::RST_DST_ROWS;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        afsw_pkg::REG_COEF_XX:  coef_xx_q  <= cfg_data_i;
        afsw_pkg::REG_COEF_XY:  coef_xy_q  <= cfg_data_i;
        afsw_pkg::REG_OFFSET_X: offset_x_q <= cfg_data_i;
        afsw_pkg::REG_COEF_YX:  coef_yx_q  <= cfg_data_i;
        afsw_pkg::REG_COEF_YY:  coef_yy_q  <= cfg_data_i;
        afsw_pkg::REG_OFFSET_Y: offset_y_q <= cfg_data_i;
        afsw_pkg::REG_DST_COLS: dst_cols_q <= cfg_data_i[afsw_pkg::LIM_W-1:0];
        afsw_pkg::REG_DST_ROWS: dst_rows_q <= cfg_data_i[afsw_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // largest linear coefficient, then side = ceil(2 * max), saturated
  always_comb begin
    mx_a = (coef_xx_q > coef_xy_q) ? coef_xx_q : coef_xy_q;
    mx_b = (coef_yx_q > coef_yy_q) ? coef_yx_q : coef_yy_q;
    mx_d = (mx_a > mx_b) ? mx_a : mx_b;
  end

  always_comb begin
    up_w = {2'b00, mx_q[afsw_pkg::COEF_W-2:0], 1'b0} + ROUND_UP;
    sq_w = up_w >> afsw_pkg::FRAC_BITS;
    if (mx_q <= 0) begin
      side_d = '0;
    end else if (sq_w > UP_W'(MAX_SPLAT)) begin
      side_d = SIDE_W'(MAX_SPLAT);
    end else begin
      side_d = sq_w[SIDE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q   <= mx_d;
    side_q <= side_d;
  end

  always_comb begin
    cfg_o.coef_xx  = coef_xx_q;
    cfg_o.coef_xy  = coef_xy_q;
    cfg_o.offset_x = offset_x_q;
    cfg_o.coef_yx  = coef_yx_q;
    cfg_o.coef_yy  = coef_yy_q;
    cfg_o.offset_y = offset_y_q;
    cfg_o.col_lim  = (dst_cols_q > afsw_pkg::LIM_MAX) ? afsw_pkg::LIM_MAX : dst_cols_q;
    cfg_o.row_lim  = (dst_rows_q > afsw_pkg::LIM_MAX) ? afsw_pkg::LIM_MAX : dst_rows_q;
  end

  assign side_o = side_q;

endmodule

/* rtl/afsw_front.sv */
`timescale 1ns / 1ps
// Front end: accepts source pixels, maps the position, clips the splat square
// and queues the resulting write window. Depends on afsw_pkg.
module afsw_front #(
  parameter int MAX_SPLAT = afsw_pkg::MAX_SPLAT_DEF,
  localparam int SIDE_W   = $clog2(MAX_SPLAT + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [afsw_pkg::COORD_BITS-1:0]   in_col_i,
  input  logic [afsw_pkg::COORD_BITS-1:0]   in_row_i,
  input  logic [afsw_pkg::CHAN_W-1:0]       in_red_i,
  input  logic [afsw_pkg::CHAN_W-1:0]       in_green_i,
  input  logic [afsw_pkg::CHAN_W-1:0]       in_blue_i,
  input  afsw_pkg::cfg_t                    cfg_i,
  input  logic [SIDE_W-1:0]                 side_i,
  input  logic                              full_i,
  output logic                              push_o,
  output afsw_pkg::span_t                   span_o
);

  localparam int ACC_W = afsw_pkg::ACC_W;
  localparam int POS_W = afsw_pkg::POS_W;
  localparam int LIM_W = afsw_pkg::LIM_W;
  localparam logic signed [ACC_W-1:0] TRUNC_ADJ = ACC_W'((1 << afsw_pkg::FRAC_BITS) - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_TRN  = 3'd3;
  localparam logic [2:0] ST_CLIP = 3'd4;

  logic [2:0] state_d, state_q;
  logic       accept, advance, empty;

  logic [afsw_pkg::COORD_BITS-1:0]       col_q, row_q;
  logic [afsw_pkg::CHAN_W-1:0]           red_q, green_q, blue_q;
  logic signed [afsw_pkg::PROD_W-1:0]    p_xx_q, p_xy_q, p_yx_q, p_yy_q;
  logic signed [ACC_W-1:0]               acc_x_q, acc_y_q;
  logic signed [POS_W-1:0]               nx_q, ny_q;
  logic signed [POS_W-1:0]               side_s, x_end, y_end, x_lim, y_lim;
  logic signed [POS_W-1:0]               x_lo, x_hi, y_lo, y_hi;

  // division by 2^FRAC_BITS, truncated toward zero
  function automatic logic signed [POS_W-1:0] trunc_pos(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] b;
    b = a + (a[ACC_W-1] ? TRUNC_ADJ : ACC_W'(0));
    return POS_W'(b >>> afsw_pkg::FRAC_BITS);
  endfunction

  assign accept     = in_valid_i && in_ready_o;
  assign advance    = (state_q == ST_CLIP) && (empty || !full_i);
  assign in_ready_o = (state_q == ST_IDLE) || advance;
  assign push_o     = (state_q == ST_CLIP) && !empty && !full_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_MUL;
      ST_MUL:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_TRN;
      ST_TRN:  state_d = ST_CLIP;
      ST_CLIP: if (advance) state_d = in_valid_i ? ST_MUL : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q   <= in_col_i;
      row_q   <= in_row_i;
      red_q   <= in_red_i;
      green_q <= in_green_i;
      blue_q  <= in_blue_i;
    end
    p_xx_q  <= cfg_i.coef_xx * $signed({1'b0, col_q});
    p_xy_q  <= cfg_i.coef_xy * $signed({1'b0, row_q});
    p_yx_q  <= cfg_i.coef_yx * $signed({1'b0, col_q});
    p_yy_q  <= cfg_i.coef_yy * $signed({1'b0, row_q});
    acc_x_q <= ACC_W'(p_xx_q) + ACC_W'(p_xy_q) + ACC_W'(cfg_i.offset_x);
    acc_y_q <= ACC_W'(p_yx_q) + ACC_W'(p_yy_q) + ACC_W'(cfg_i.offset_y);
    nx_q    <= trunc_pos(acc_x_q);
    ny_q    <= trunc_pos(acc_y_q);
  end

  always_comb begin
    side_s = $signed(POS_W'(side_i));
    x_lim  = $signed(POS_W'(cfg_i.col_lim));
    y_lim  = $signed(POS_W'(cfg_i.row_lim));
    x_end  = nx_q + side_s;
    y_end  = ny_q + side_s;
    x_lo   = (nx_q < 0) ? POS_W'(0) : nx_q;
    y_lo   = (ny_q < 0) ? POS_W'(0) : ny_q;
    x_hi   = (x_end < x_lim) ? x_end : x_lim;
    y_hi   = (y_end < y_lim) ? y_end : y_lim;
    empty  = (x_lo >= x_hi) || (y_lo >= y_hi);
  end

  always_comb begin
    span_o.col_lo = x_lo[LIM_W-1:0];
    span_o.col_hi = x_hi[LIM_W-1:0];
    span_o.row_lo = y_lo[LIM_W-1:0];
    span_o.row_hi = y_hi[LIM_W-1:0];
    span_o.red    = red_q;
    span_o.green  = green_q;
    span_o.blue   = blue_q;
  end

endmodule

/* rtl/afsw_fifo.sv */
`timescale 1ns / 1ps
// Short queue of write windows between front and back end.
// Depends on afsw_pkg.
module afsw_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  afsw_pkg::span_t span_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output afsw_pkg::span_t span_o
);

  localparam int DEPTH = afsw_pkg::Q_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  afsw_pkg::span_t    mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : PTR_W'(p + 1'b1);
  endfunction

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign span_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= span_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/afsw_back.sv */
`timescale 1ns / 1ps
// Back end: walks a write window row by row, one write per cycle while the output
// is not stalled, through an output register. Depends on afsw_pkg.
module afsw_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              empty_i,
  input  afsw_pkg::span_t                   span_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [afsw_pkg::COORD_BITS-1:0]   out_col_o,
  output logic [afsw_pkg::COORD_BITS-1:0]   out_row_o,
  output logic [afsw_pkg::CHAN_W-1:0]       out_red_o,
  output logic [afsw_pkg::CHAN_W-1:0]       out_green_o,
  output logic [afsw_pkg::CHAN_W-1:0]       out_blue_o,
  output logic                              out_last_o
);

  localparam int LIM_W = afsw_pkg::LIM_W;

  afsw_pkg::span_t                  span_q;
  logic                             busy_q, out_valid_q;
  logic [LIM_W-1:0]                 col_q, row_q;
  logic [afsw_pkg::COORD_BITS-1:0]  o_col_q, o_row_q;
  logic [afsw_pkg::CHAN_W-1:0]      o_red_q, o_green_q, o_blue_q;
  logic                             o_last_q;
  logic                             emit, col_end, row_end;

  assign pop_o   = !busy_q && !empty_i;
  assign emit    = busy_q && (!out_valid_q || out_ready_i);
  assign col_end = (LIM_W'(col_q + 1'b1) == span_q.col_hi);
  assign row_end = (LIM_W'(row_q + 1'b1) == span_q.row_hi);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
      end else if (emit && col_end && row_end) begin
        busy_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      span_q <= span_i;
      col_q  <= span_i.col_lo;
      row_q  <= span_i.row_lo;
    end else if (emit) begin
      if (col_end) begin
        col_q <= span_q.col_lo;
        row_q <= LIM_W'(row_q + 1'b1);
      end else begin
        col_q <= LIM_W'(col_q + 1'b1);
      end
    end
    if (emit) begin
      o_col_q   <= col_q[afsw_pkg::COORD_BITS-1:0];
      o_row_q   <= row_q[afsw_pkg::COORD_BITS-1:0];
      o_red_q   <= span_q.red;
      o_green_q <= span_q.green;
      o_blue_q  <= span_q.blue;
      o_last_q  <= col_end && row_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_col_o   = o_col_q;
  assign out_row_o   = o_row_q;
  assign out_red_o   = o_red_q;
  assign out_green_o = o_green_q;
  assign out_blue_o  = o_blue_q;
  assign out_last_o  = o_last_q;

endmodule

/* rtl/affine_forward_splat_warp.sv */
`timescale 1ns / 1ps
// Affine forward splat warp, top level. The front end steps each pixel through map
// multiply, sum, truncate and clip, and takes no new pixel until the last one
// leaves clip; the back end loads each window from the queue, then issues one
// write per cycle while the output is not stalled.
// Async active-low reset: identity matrix, 640x480 bounds, queue empty.
module affine_forward_splat_warp #(
  parameter int MAX_SPLAT = afsw_pkg::MAX_SPLAT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // src_col[11:0], src_row[23:12], red[31:24], green[39:32], blue[47:40]
  input  logic [47:0]                     s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // dst_col[11:0], dst_row[23:12], out_red[31:24], out_green[39:32], out_blue[47:40]
  output logic [47:0]                     m_axis_tdata,
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [afsw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [afsw_pkg::COEF_W-1:0]     cfg_data_i
);

  localparam int SIDE_W = $clog2(MAX_SPLAT + 1);
  localparam int CB     = afsw_pkg::COORD_BITS;
  localparam int CW     = afsw_pkg::CHAN_W;

  afsw_pkg::cfg_t   cfg;
  afsw_pkg::span_t  push_span, pop_span;
  logic [SIDE_W-1:0] side;
  logic             push, pop, q_full, q_empty;
  logic [CB-1:0]    o_col, o_row;
  logic [CW-1:0]    o_red, o_green, o_blue;

  assign cfg_ready_o = 1'b1;

  afsw_cfg #(.MAX_SPLAT(MAX_SPLAT)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .side_o      (side)
  );

  afsw_front #(.MAX_SPLAT(MAX_SPLAT)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_col_i   (s_axis_tdata[CB-1:0]),
    .in_row_i   (s_axis_tdata[2*CB-1:CB]),
    .in_red_i   (s_axis_tdata[2*CB+CW-1:2*CB]),
    .in_green_i (s_axis_tdata[2*CB+2*CW-1:2*CB+CW]),
    .in_blue_i  (s_axis_tdata[2*CB+3*CW-1:2*CB+2*CW]),
    .cfg_i      (cfg),
    .side_i     (side),
    .full_i     (q_full),
    .push_o     (push),
    .span_o     (push_span)
  );

  afsw_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .span_i  (push_span),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .span_o  (pop_span)
  );

  afsw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .span_i      (pop_span),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_col_o   (o_col),
    .out_row_o   (o_row),
    .out_red_o   (o_red),
    .out_green_o (o_green),
    .out_blue_o  (o_blue),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {o_blue, o_green, o_red, o_row, o_col};

endmodule

/* tb/affine_forward_splat_warp_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for affine_forward_splat_warp: an in-bench splat predictor
// checks every destination write. Runs directed and random pixel streams over several
// matrix settings. Depends on afsw_pkg and the affine_forward_splat_warp RTL.
module affine_forward_splat_warp_tb;

  localparam int SETTLE_CYCLES    = 20;
  localparam int HOLD_CYCLES      = 300;
  localparam int IDLE_LIMIT       = 4000;
  localparam int RANDOM_PHASES    = 8;
  localparam int PIXELS_PER_PHASE = 25;
  localparam int GAP_MAX          = 4;
  localparam int unsigned COEF_SPAN   = 32'h0004_0000;
  localparam int unsigned OFFSET_SPAN = 32'h0040_0000;
  localparam logic [afsw_pkg::CFG_IDX_W-1:0] REG_UNUSED = afsw_pkg::CFG_IDX_W'(15);

  typedef struct packed {
    logic [afsw_pkg::CHAN_W-1:0]     blue;
    logic [afsw_pkg::CHAN_W-1:0]     green;
    logic [afsw_pkg::CHAN_W-1:0]     red;
    logic [afsw_pkg::COORD_BITS-1:0] row;
    logic [afsw_pkg::COORD_BITS-1:0] col;
  } pixel_t;

  typedef struct packed {
    logic                            last;
    logic [afsw_pkg::CHAN_W-1:0]     blue;
    logic [afsw_pkg::CHAN_W-1:0]     green;
    logic [afsw_pkg::CHAN_W-1:0]     red;
    logic [afsw_pkg::COORD_BITS-1:0] row;
    logic [afsw_pkg::COORD_BITS-1:0] col;
  } write_t;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [47:0]                    s_axis_tdata  = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [47:0]                    m_axis_tdata;
  logic                           m_axis_tlast;
  logic                           cfg_valid_i   = 1'b0;
  logic                           cfg_ready_o;
  logic [afsw_pkg::CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [afsw_pkg::COEF_W-1:0]    cfg_data_i    = '0;

  // predictor copy of the register file
  logic signed [afsw_pkg::COEF_W-1:0] k_xx, k_xy, k_ox, k_yx, k_yy, k_oy;
  logic [afsw_pkg::LIM_W-1:0]         n_cols, n_rows;

  pixel_t pix_q[$];
  write_t splat_q[$];

  logic pix_taken = 1'b0;
  logic res_taken = 1'b0;
  logic cfg_taken = 1'b0;
  int   errors      = 0;
  int   idle_cycles = 0;
  int   src_gap_max = 0;
  int   snk_gap_max = 0;
  int   src_wait    = 0;
  int   snk_wait    = 0;
  int   hold_left   = 0;
  bit   hold_req    = 1'b0;
  bit   hold_done   = 1'b0;
  pixel_t next_pix;

  affine_forward_splat_warp i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Q16.16 to integer, toward zero
  function automatic longint q_to_int(input longint a);
    if (a < 0) begin
      return -((-a) >>> afsw_pkg::FRAC_BITS);
    end
    return a >>> afsw_pkg::FRAC_BITS;
  endfunction

  function automatic logic [afsw_pkg::COEF_W-1:0] rand_q(input int unsigned span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // size register word with junk in the unused upper bits
  function automatic logic [afsw_pkg::COEF_W-1:0] rand_dim();
    logic [afsw_pkg::COEF_W-1:0] dim;
    if ($urandom_range(0, 7) == 0) begin
      dim = $urandom_range(0, 8191);
    end else begin
      dim = $urandom_range(1, 128);
    end
    return ($urandom() & 32'hFFFF_E000) | dim;
  endfunction

  task automatic apply_reg(input logic [afsw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [afsw_pkg::COEF_W-1:0] val);
    case (idx)
      afsw_pkg::REG_COEF_XX:  k_xx = val;
      afsw_pkg::REG_COEF_XY:  k_xy = val;
      afsw_pkg::REG_OFFSET_X: k_ox = val;
      afsw_pkg::REG_COEF_YX:  k_yx = val;
      afsw_pkg::REG_COEF_YY:  k_yy = val;
      afsw_pkg::REG_OFFSET_Y: k_oy = val;
      afsw_pkg::REG_DST_COLS: n_cols = val[afsw_pkg::LIM_W-1:0];
      afsw_pkg::REG_DST_ROWS: n_rows = val[afsw_pkg::LIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic predict_splat(input pixel_t p);
    longint c, r, top, side, px, py, cb, rb, x, y;
    int     first;
    write_t w;
    c   = longint'(p.col);
    r   = longint'(p.row);
    top = longint'(k_xx);
    if (k_xy > top) top = longint'(k_xy);
    if (k_yx > top) top = longint'(k_yx);
    if (k_yy > top) top = longint'(k_yy);
    if (2 * top <= 0) return;
    side = (2 * top + (64'sd1 <<< afsw_pkg::FRAC_BITS) - 1) >>> afsw_pkg::FRAC_BITS;
    if (side > afsw_pkg::MAX_SPLAT_DEF) side = afsw_pkg::MAX_SPLAT_DEF;
    px = q_to_int(k_xx * c + k_xy * r + k_ox);
    py = q_to_int(k_yx * c + k_yy * r + k_oy);
    cb = longint'((n_cols > afsw_pkg::LIM_MAX) ? afsw_pkg::LIM_MAX : n_cols);
    rb = longint'((n_rows > afsw_pkg::LIM_MAX) ? afsw_pkg::LIM_MAX : n_rows);
    first = splat_q.size();
    for (y = py; y < py + side; y++) begin
      for (x = px; x < px + side; x++) begin
        if (y >= 0 && y < rb && x >= 0 && x < cb) begin
          w.col   = x[afsw_pkg::COORD_BITS-1:0];
          w.row   = y[afsw_pkg::COORD_BITS-1:0];
          w.red   = p.red;
          w.green = p.green;
          w.blue  = p.blue;
          w.last  = 1'b0;
          splat_q.push_back(w);
        end
      end
    end
    if (splat_q.size() > first) splat_q[splat_q.size() - 1].last = 1'b1;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic check_write(input write_t got);
    write_t want;
    if (splat_q.size() == 0) begin
      $error("write to col %0d row %0d with nothing expected", got.col, got.row);
      errors++;
      return;
    end
    want = splat_q.pop_front();
    check_field("dst_col", 32'(want.col), 32'(got.col));
    check_field("dst_row", 32'(want.row), 32'(got.row));
    check_field("out_red", 32'(want.red), 32'(got.red));
    check_field("out_green", 32'(want.green), 32'(got.green));
    check_field("out_blue", 32'(want.blue), 32'(got.blue));
    check_field("last", 32'(want.last), 32'(got.last));
  endtask

  // monitor: transfers seen at the rising edge
  always @(posedge clk_i) begin
    pix_taken <= s_axis_tvalid && s_axis_tready;
    res_taken <= m_axis_tvalid && m_axis_tready;
    cfg_taken <= cfg_valid_i && cfg_ready_o;
    if (!rst_ni) begin
      k_xx        = afsw_pkg::RST_COEF_ONE;
      k_xy        = '0;
      k_ox        = '0;
      k_yx        = '0;
      k_yy        = afsw_pkg::RST_COEF_ONE;
      k_oy        = '0;
      n_cols      = afsw_pkg::RST_DST_COLS;
      n_rows      = afsw_pkg::RST_DST_ROWS;
      idle_cycles = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) apply_reg(cfg_index_i, cfg_data_i);
      if (m_axis_tvalid && m_axis_tready) check_write(write_t'({m_axis_tlast, m_axis_tdata}));
      if (s_axis_tvalid && s_axis_tready) predict_splat(pixel_t'(s_axis_tdata));
      if ((cfg_valid_i && cfg_ready_o) || (m_axis_tvalid && m_axis_tready) ||
          (s_axis_tvalid && s_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // pixel driver
  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && !pix_taken)) begin
      if (src_wait > 0) begin
        src_wait--;
        s_axis_tvalid <= 1'b0;
      end else if (pix_q.size() > 0) begin
        next_pix = pix_q.pop_front();
        s_axis_tdata  <= next_pix;
        s_axis_tvalid <= 1'b1;
        src_wait = int'($urandom_range(0, src_gap_max));
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // write sink
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (m_axis_tready && !res_taken) begin
        m_axis_tready <= 1'b1;
      end else if (snk_wait > 0) begin
        snk_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        snk_wait = int'($urandom_range(0, snk_gap_max));
      end
    end
  end

  task automatic write_reg(input logic [afsw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [afsw_pkg::COEF_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_matrix(input logic [afsw_pkg::COEF_W-1:0] xx, xy, ox, yx, yy, oy,
                            cols, rows);
    write_reg(afsw_pkg::REG_COEF_XX, xx);
    write_reg(afsw_pkg::REG_COEF_XY, xy);
    write_reg(afsw_pkg::REG_OFFSET_X, ox);
    write_reg(afsw_pkg::REG_COEF_YX, yx);
    write_reg(afsw_pkg::REG_COEF_YY, yy);
    write_reg(afsw_pkg::REG_OFFSET_Y, oy);
    write_reg(afsw_pkg::REG_DST_COLS, cols);
    write_reg(afsw_pkg::REG_DST_ROWS, rows);
  endtask

  task automatic add_pixel(input int col, row, red, green, blue);
    pixel_t p;
    p.col   = afsw_pkg::COORD_BITS'(col);
    p.row   = afsw_pkg::COORD_BITS'(row);
    p.red   = afsw_pkg::CHAN_W'(red);
    p.green = afsw_pkg::CHAN_W'(green);
    p.blue  = afsw_pkg::CHAN_W'(blue);
    pix_q.push_back(p);
  endtask

  // everything drained, then room for pixels in flight that make no writes
  task automatic wait_idle();
    while (pix_q.size() != 0 || s_axis_tvalid || splat_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset identity matrix, 640x480: plain 2x2, corner, fully off image, right edge
    src_gap_max = 0;
    snk_gap_max = 0;
    add_pixel(0, 0, 8'h00, 8'h00, 8'h00);
    add_pixel(639, 479, 8'hFF, 8'hFF, 8'hFF);
    add_pixel(4095, 4095, 8'hA5, 8'h5A, 8'hC3);
    add_pixel(638, 0, 8'h12, 8'h34, 8'h56);
    wait_idle();

    // largest coefficient zero: no writes; unknown register index ignored
    src_gap_max = GAP_MAX;
    snk_gap_max = GAP_MAX;
    set_matrix(32'hFFFF_0000, 32'h0, 32'h0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 640, 480);
    write_reg(REG_UNUSED, 32'h0001_0000);
    add_pixel(10, 10, 8'h01, 8'h02, 8'h03);
    add_pixel(0, 0, 8'h80, 8'h40, 8'h20);
    wait_idle();

    // scale 4: side reaches MAX_SPLAT, negative offset truncates toward zero, column bound saturates
    set_matrix(32'h0004_0000, 32'h0, 32'h0000_8000, 32'h0, 32'h0004_0000, 32'hFFFF_8000,
               32'h0000_1FFF, 32'h0000_1000);
    add_pixel(0, 0, 8'h11, 8'h22, 8'h33);
    add_pixel(1023, 1023, 8'h44, 8'h55, 8'h66);
    add_pixel(1024, 1024, 8'h77, 8'h88, 8'h99);
    wait_idle();

    // side 1 into a 1x1 destination, with shear
    set_matrix(32'h0000_8000, 32'h0000_4000, 32'h0, 32'hFFFF_C000, 32'h0000_8000, 32'h0, 1, 1);
    add_pixel(0, 0, 8'hFE, 8'h01, 8'h7F);
    add_pixel(1, 1, 8'h0F, 8'hF0, 8'h3C);
    add_pixel(2, 0, 8'h10, 8'h20, 8'h30);
    add_pixel(4, 0, 8'h40, 8'h50, 8'h60);
    wait_idle();

    // side rounds up to 2, zero destination width
    set_matrix(32'h0000_8001, 32'h0, 32'h0, 32'h0, 32'h0000_7FFF, 32'h0, 0, 480);
    add_pixel(5, 5, 8'hAA, 8'hBB, 8'hCC);
    add_pixel(0, 0, 8'hDD, 8'hEE, 8'hFF);
    wait_idle();

    // extreme coefficients and offsets, position far outside
    set_matrix(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h8000_0000, 4096, 4096);
    add_pixel(4095, 4095, 8'h01, 8'h01, 8'h01);
    add_pixel(4095, 0, 8'h02, 8'h02, 8'h02);
    add_pixel(0, 4095, 8'h03, 8'h03, 8'h03);
    wait_idle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if ($urandom_range(0, 3) == 0) begin
        set_matrix($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom(), $urandom());
      end else begin
        set_matrix(rand_q(COEF_SPAN), rand_q(COEF_SPAN), rand_q(OFFSET_SPAN),
                   rand_q(COEF_SPAN), rand_q(COEF_SPAN), rand_q(OFFSET_SPAN),
                   rand_dim(), rand_dim());
      end
      src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      snk_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      if (ph == 1) hold_req = 1'b1;
      for (int i = 0; i < PIXELS_PER_PHASE; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
        end else begin
          add_pixel($urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
        end
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
